[rtl/shtl_pkg.sv]
// shared types, codes and widths for the sorted hash table lookup unit
package shtl_pkg;

   localparam int CMD_W     = 2;
   localparam int HASH_W    = 32;
   localparam int OFFSET_W  = 32;
   localparam int ADDR_W    = 32;
   localparam int MATCH_W   = 10;
   localparam int STATUS_W  = 2;

   localparam int DEFAULT_TABLE_DEPTH = 1024;

   // request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // raw command codes on the request port
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_IGNORE = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE = 2'd0,
      ST_FULL = 2'd1,
      ST_HIT  = 2'd2,
      ST_MISS = 2'd3
   } status_type;

   typedef struct packed {
      op_type                op;
      logic [HASH_W-1:0]     key_hash;
      logic [OFFSET_W-1:0]   entry_offset;
   } item_type;

endpackage

[rtl/shtl_front.sv]
// request intake: classifies commands and queues them for the search engine
module shtl_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [shtl_pkg::CMD_W-1:0]   req_command,
   input  logic [shtl_pkg::HASH_W-1:0]  req_key_hash,
   input  logic [shtl_pkg::OFFSET_W-1:0] req_entry_offset,
   output logic                         q_valid,
   output shtl_pkg::item_type           q_item,
   input  logic                         q_pop
);

   shtl_pkg::item_type                  queue_ff [shtl_pkg::QUEUE_DEPTH];
   logic [shtl_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [shtl_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [shtl_pkg::QCNT_W-1:0]         count_ff, count_in;
   logic                                push;
   logic                                pop;
   shtl_pkg::item_type                  item_new;

   function automatic logic [shtl_pkg::QPTR_W-1:0] ptr_next(
      input logic [shtl_pkg::QPTR_W-1:0] ptr);
      if (ptr == shtl_pkg::QPTR_W'(shtl_pkg::QUEUE_DEPTH - 1))
         return '0;
      else
         return ptr + shtl_pkg::QPTR_W'(1);
   endfunction

   always_comb begin
      item_new.key_hash     = req_key_hash;
      item_new.entry_offset = req_entry_offset;
      case (req_command)
         shtl_pkg::CMD_CLEAR:  item_new.op = shtl_pkg::OP_CLEAR;
         shtl_pkg::CMD_APPEND: item_new.op = shtl_pkg::OP_APPEND;
         shtl_pkg::CMD_LOOKUP: item_new.op = shtl_pkg::OP_LOOKUP;
         default:              item_new.op = shtl_pkg::OP_IGNORE;
      endcase
   end

   assign req_stall = (count_ff == shtl_pkg::QCNT_W'(shtl_pkg::QUEUE_DEPTH));
   assign q_valid   = (count_ff != '0);
   assign q_item    = queue_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)
         count_in = count_ff + shtl_pkg::QCNT_W'(1);
      else if (pop && !push)
         count_in = count_ff - shtl_pkg::QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         queue_ff[wr_ptr_ff] <= item_new;
   end

endmodule

[rtl/shtl_back.sv]
// table storage, binary search engine and response register
module shtl_back #(
   parameter int TABLE_DEPTH = shtl_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [shtl_pkg::ADDR_W-1:0]    csr_write_data,
   input  logic                           q_valid,
   input  shtl_pkg::item_type             q_item,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [shtl_pkg::STATUS_W-1:0]  rsp_status,
   output logic [shtl_pkg::MATCH_W-1:0]   rsp_match_index,
   output logic [shtl_pkg::ADDR_W-1:0]    rsp_text_address
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = IDX_W + 1;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SEARCH = 4'b0010,
      S_ADDR   = 4'b0100,
      S_RESP   = 4'b1000
   } state_type;

   logic [shtl_pkg::HASH_W-1:0]   hash_mem   [TABLE_DEPTH];
   logic [shtl_pkg::OFFSET_W-1:0] offset_mem [TABLE_DEPTH];

   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [CNT_W-1:0]              lo_ff, lo_in;
   logic [CNT_W-1:0]              hi_ff, hi_in;      // exclusive upper bound
   logic [CNT_W-1:0]              mid_ff, mid_in;
   logic [shtl_pkg::HASH_W-1:0]   key_ff, key_in;
   logic [shtl_pkg::ADDR_W-1:0]   base_ff;
   logic [shtl_pkg::HASH_W-1:0]   hash_rd_ff;
   logic [shtl_pkg::OFFSET_W-1:0] offset_rd_ff;
   shtl_pkg::status_type          status_ff, status_in;
   logic [shtl_pkg::MATCH_W-1:0]  index_ff, index_in;
   logic [shtl_pkg::ADDR_W-1:0]   addr_ff, addr_in;

   logic                          mem_we;
   logic [CNT_W-1:0]              next_lo, next_hi;
   logic [CNT_W:0]                mid_sum;
   logic [IDX_W+shtl_pkg::MATCH_W-1:0] index_wide;

   assign index_wide = {{shtl_pkg::MATCH_W{1'b0}}, mid_ff[IDX_W-1:0]};
   assign next_lo    = (key_ff > hash_rd_ff) ? mid_ff + CNT_W'(1) : lo_ff;
   assign next_hi    = (key_ff > hash_rd_ff) ? hi_ff : mid_ff;
   assign mid_sum    = {1'b0, next_lo} + {1'b0, next_hi} - (CNT_W+1)'(1);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      key_in    = key_ff;
      status_in = status_ff;
      index_in  = index_ff;
      addr_in   = addr_ff;
      mem_we    = 1'b0;
      q_pop     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               key_in    = q_item.key_hash;
               status_in = shtl_pkg::ST_DONE;
               index_in  = '0;
               addr_in   = '0;
               state_in  = S_RESP;
               case (q_item.op)
                  shtl_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  shtl_pkg::OP_APPEND: begin
                     if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                        status_in = shtl_pkg::ST_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  shtl_pkg::OP_LOOKUP: begin
                     if (count_ff == '0) begin
                        status_in = shtl_pkg::ST_MISS;
                     end else begin
                        lo_in    = '0;
                        hi_in    = count_ff;
                        mid_in   = (count_ff - CNT_W'(1)) >> 1;
                        state_in = S_SEARCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (key_ff == hash_rd_ff) begin
               state_in = S_ADDR;
            end else begin
               lo_in = next_lo;
               hi_in = next_hi;
               if (next_lo < next_hi) begin
                  mid_in = mid_sum[CNT_W:1];
               end else begin
                  status_in = shtl_pkg::ST_MISS;
                  state_in  = S_RESP;
               end
            end
         end
         S_ADDR: begin
            status_in = shtl_pkg::ST_HIT;
            index_in  = index_wide[shtl_pkg::MATCH_W-1:0];
            addr_in   = base_ff + offset_rd_ff;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall)
               state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         base_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_write_enable)
            base_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      index_ff  <= index_in;
      addr_ff   <= addr_in;
   end

   // hash memory: append write, probe read
   always_ff @(posedge clock) begin
      if (mem_we)
         hash_mem[count_ff[IDX_W-1:0]] <= q_item.key_hash;
      hash_rd_ff <= hash_mem[mid_in[IDX_W-1:0]];
   end

   // offset memory: read at the current probe, used once it hits
   always_ff @(posedge clock) begin
      if (mem_we)
         offset_mem[count_ff[IDX_W-1:0]] <= q_item.entry_offset;
      offset_rd_ff <= offset_mem[mid_ff[IDX_W-1:0]];
   end

   assign rsp_valid        = (state_ff == S_RESP);
   assign rsp_status       = status_ff;
   assign rsp_match_index  = index_ff;
   assign rsp_text_address = addr_ff;

endmodule

[rtl/sorted_hash_table_lookup_unit.sv]
// top level of the sorted hash table lookup unit
//
// Holds up to TABLE_DEPTH entries of (32-bit key hash, 32-bit text offset),
// appended in ascending hash order; clear empties the table, lookup runs a
// binary search and returns hit/miss, the hit index and text_base plus the
// stored offset. Every request gives exactly one response. Requests enter a
// two-deep queue, so up to two more requests are taken while a response waits
// on rsp_stall. From the queue head, clear, append and ignored commands go
// straight to the response; a lookup probes the table and, on a hit, forms
// the text address before the response; at most ceil(log2(n+1)) probes for
// n loaded entries, so up to 11 probes with 1024 entries. The engine takes
// its next request the cycle after the response is accepted. The probe
// rate is set by the hash memory's single registered read port, read once
// per cycle.
// No clearing pass follows reset: only entries below the fill count are used.
// text_base is written through csr_write_enable/csr_write_data and must only
// change while no request is in flight.
module sorted_hash_table_lookup_unit #(
   parameter int TABLE_DEPTH = shtl_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_write_enable,
   input  logic [shtl_pkg::ADDR_W-1:0]     csr_write_data,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [shtl_pkg::CMD_W-1:0]      req_command,
   input  logic [shtl_pkg::HASH_W-1:0]     req_key_hash,
   input  logic [shtl_pkg::OFFSET_W-1:0]   req_entry_offset,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [shtl_pkg::STATUS_W-1:0]   rsp_status,
   output logic [shtl_pkg::MATCH_W-1:0]    rsp_match_index,
   output logic [shtl_pkg::ADDR_W-1:0]     rsp_text_address
);

   // queued request handed from intake to the search engine
   logic                q_valid;
   logic                q_pop;
   shtl_pkg::item_type  q_item;

   // intake: decode command, buffer request
   shtl_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_key_hash     (req_key_hash),
      .req_entry_offset (req_entry_offset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop)
   );

   // engine: table memories, fill count, search, response register
   shtl_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_match_index  (rsp_match_index),
      .rsp_text_address (rsp_text_address)
   );

endmodule

[rtl/shtl_checker.sv]
// port-level checks for the sorted hash table lookup unit, bound to the top
module shtl_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_stall,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [shtl_pkg::STATUS_W-1:0]   rsp_status,
   input  logic [shtl_pkg::MATCH_W-1:0]    rsp_match_index,
   input  logic [shtl_pkg::ADDR_W-1:0]     rsp_text_address
);

   // nothing pending and room for requests right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("response or stall active after reset");

   // a held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status)
         && $stable(rsp_match_index) && $stable(rsp_text_address)))
      else $error("stalled response changed");

   // only a hit carries an index and an address
   a_nonhit_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == shtl_pkg::ST_DONE || rsp_status == shtl_pkg::ST_FULL
         || rsp_status == shtl_pkg::ST_MISS))
      |-> (rsp_match_index == '0 && rsp_text_address == '0))
      else $error("non-hit response with nonzero index or address");

endmodule

bind sorted_hash_table_lookup_unit shtl_checker u_shtl_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_match_index  (rsp_match_index),
   .rsp_text_address (rsp_text_address)
);

[verif/testbench.sv]
`timescale 1ns / 1ps
// self-checking testbench for the sorted hash table lookup unit
module testbench;

   localparam int DEPTH        = shtl_pkg::DEFAULT_TABLE_DEPTH;
   localparam int CYCLE_LIMIT  = 300000;  // far above the slowest legal run
   localparam int SETTLE       = 16;      // a little more than one full-depth search
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_REPORTS  = 10;
   localparam int LONG_HOLD    = 300;     // receiver hold-off that backs up the queue

   typedef struct {
      shtl_pkg::status_type               status;
      logic [shtl_pkg::MATCH_W-1:0]       match_index;
      logic [shtl_pkg::ADDR_W-1:0]        text_address;
   } lookup_result_type;

   // shadow copy of the table; works out the answer for every accepted request
   class lookup_scoreboard_type;
      logic [shtl_pkg::HASH_W-1:0]   hash_mem [DEPTH];
      logic [shtl_pkg::OFFSET_W-1:0] offset_mem [DEPTH];
      int                            fill;
      logic [shtl_pkg::ADDR_W-1:0]   base;
      lookup_result_type             pending_results [$];
      int                            mismatches;

      function new();
         fill       = 0;
         base       = '0;
         mismatches = 0;
      endfunction

      function void set_base(logic [shtl_pkg::ADDR_W-1:0] value);
         base = value;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function void note_request(shtl_pkg::op_type op, logic [shtl_pkg::HASH_W-1:0] key,
                                 logic [shtl_pkg::OFFSET_W-1:0] offset);
         lookup_result_type r;
         int lo, hi, mid;
         bit found;
         r.status       = shtl_pkg::ST_DONE;
         r.match_index  = '0;
         r.text_address = '0;
         case (op)
            shtl_pkg::OP_CLEAR: fill = 0;
            shtl_pkg::OP_APPEND: begin
               if (fill >= DEPTH) begin
                  r.status = shtl_pkg::ST_FULL;
               end else begin
                  hash_mem[fill]   = key;
                  offset_mem[fill] = offset;
                  fill++;
               end
            end
            shtl_pkg::OP_LOOKUP: begin
               // same probe order as a sorted table, even when it is not sorted
               lo    = 0;
               hi    = fill - 1;
               found = 0;
               while (lo <= hi && !found) begin
                  mid = (lo + hi) / 2;
                  if (key == hash_mem[mid]) begin
                     found          = 1;
                     r.status       = shtl_pkg::ST_HIT;
                     r.match_index  = mid[shtl_pkg::MATCH_W-1:0];
                     r.text_address = base + offset_mem[mid];
                  end else if (key > hash_mem[mid]) begin
                     lo = mid + 1;
                  end else begin
                     hi = mid - 1;
                  end
               end
               if (!found) r.status = shtl_pkg::ST_MISS;
            end
            default: ;  // unused command code leaves the table alone
         endcase
         pending_results.push_back(r);
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("mismatch: %s", what);
      endfunction

      function void check_response(logic [shtl_pkg::STATUS_W-1:0] status,
                                   logic [shtl_pkg::MATCH_W-1:0] idx,
                                   logic [shtl_pkg::ADDR_W-1:0] addr);
         lookup_result_type r;
         if (pending_results.size() == 0) begin
            flag($sformatf("response with nothing pending: status %0d index %0d address %h",
                           status, idx, addr));
            return;
         end
         r = pending_results.pop_front();
         if (status !== r.status || idx !== r.match_index || addr !== r.text_address)
            flag($sformatf({"expected status %0d index %0d address %h, ",
                            "got status %0d index %0d address %h"},
                           r.status, r.match_index, r.text_address, status, idx, addr));
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              csr_write_enable;
   logic [shtl_pkg::ADDR_W-1:0]       csr_write_data;
   logic                              req_valid;
   logic                              req_stall;
   logic [shtl_pkg::CMD_W-1:0]        req_command;
   logic [shtl_pkg::HASH_W-1:0]       req_key_hash;
   logic [shtl_pkg::OFFSET_W-1:0]     req_entry_offset;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [shtl_pkg::STATUS_W-1:0]     rsp_status;
   logic [shtl_pkg::MATCH_W-1:0]      rsp_match_index;
   logic [shtl_pkg::ADDR_W-1:0]       rsp_text_address;

   lookup_scoreboard_type sb;
   int               send_idle_pct;   // chance in 100 that the sender idles a cycle
   int               rsp_stall_pct;   // chance in 100 that the receiver stalls a cycle
   bit               rsp_hold_req;    // asks the receiver for one long hold-off
   int               sent_count;
   int               cycle_count;

   sorted_hash_table_lookup_unit #(.TABLE_DEPTH(DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_key_hash     (req_key_hash),
      .req_entry_offset (req_entry_offset),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_match_index  (rsp_match_index),
      .rsp_text_address (rsp_text_address)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // responses are taken at the rising edge when valid and not stalled
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_status, rsp_match_index, rsp_text_address);
   end

   // receiver: random stalls, plus one long hold-off counted here
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   // offer one request; entered and left at a falling edge
   task automatic send_request(input shtl_pkg::op_type op,
                               input logic [shtl_pkg::HASH_W-1:0] key,
                               input logic [shtl_pkg::OFFSET_W-1:0] offset);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= op;
      req_key_hash     <= key;
      req_entry_offset <= offset;
      @(posedge clock);
      while (req_stall) @(posedge clock);  // payload holds while stalled
      sb.note_request(op, key, offset);
      sent_count++;
      @(negedge clock);
   endtask

   // base may only move with nothing in flight
   task automatic write_text_base(input logic [shtl_pkg::ADDR_W-1:0] value);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      sb.set_base(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // load a sorted table with random content, then look it up;
   // sprinkled with unused commands and out-of-order appends
   task automatic run_table_sequence();
      bit [shtl_pkg::HASH_W-1:0] keys [$];
      bit [shtl_pkg::HASH_W-1:0] key;
      int n, lookups, pick, i;
      bit narrow;
      n      = ($urandom_range(9) == 0) ? $urandom_range(41, 160) : $urandom_range(1, 40);
      narrow = ($urandom_range(5) == 0);  // small key range gives duplicates
      for (i = 0; i < n; i++)
         keys.push_back(narrow ? $urandom_range(0, 31) : $urandom());
      keys.sort();
      if ($urandom_range(99) < 85)
         send_request(shtl_pkg::OP_CLEAR, $urandom(), $urandom());
      foreach (keys[k]) begin
         if ($urandom_range(29) == 0)
            send_request(shtl_pkg::OP_IGNORE, $urandom(), $urandom());
         if ($urandom_range(39) == 0)
            send_request(shtl_pkg::OP_APPEND, $urandom(), $urandom());
         send_request(shtl_pkg::OP_APPEND, keys[k], $urandom());
      end
      lookups = $urandom_range(n / 2 + 1, 2 * n);
      repeat (lookups) begin
         pick = $urandom_range(9);
         key  = keys[$urandom_range(keys.size() - 1)];
         if (pick == 9)      key = $urandom();  // mostly misses
         else if (pick == 8) key = key + 1;      // just past a stored hash
         else if (pick == 7) key = key - 1;      // just below a stored hash
         send_request(shtl_pkg::OP_LOOKUP, key, $urandom());
      end
   endtask

   task automatic run_random_phase(input int send_idle, input int rsp_idle, input int items);
      int target;
      send_idle_pct  = send_idle;
      rsp_stall_pct <= rsp_idle;
      target         = sent_count + items;
      while (sent_count < target) run_table_sequence();
   endtask

   initial begin
      bit [shtl_pkg::HASH_W-1:0] full_keys [$];
      int i;
      sb               = new();
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_command      = shtl_pkg::OP_CLEAR;
      req_key_hash     = '0;
      req_entry_offset = '0;
      send_idle_pct    = 0;
      rsp_stall_pct    = 0;
      rsp_hold_req     = 1'b0;
      sent_count       = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      write_text_base('0);

      // directed: empty table, unused command, extremes of hash and offset
      send_request(shtl_pkg::OP_LOOKUP, 32'h0, 32'h0);
      send_request(shtl_pkg::OP_IGNORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(shtl_pkg::OP_APPEND, 32'h0, 32'hFFFF_FFFF);
      send_request(shtl_pkg::OP_APPEND, 32'h5, 32'h0);
      send_request(shtl_pkg::OP_APPEND, 32'hFFFF_FFFF, 32'h1234_5678);
      send_request(shtl_pkg::OP_LOOKUP, 32'h0, 32'h0);
      send_request(shtl_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
      send_request(shtl_pkg::OP_LOOKUP, 32'h5, 32'h0);
      send_request(shtl_pkg::OP_LOOKUP, 32'h3, 32'h0);
      send_request(shtl_pkg::OP_LOOKUP, 32'hFFFF_FFFE, 32'h0);
      // clear drops everything
      send_request(shtl_pkg::OP_CLEAR, 32'h0, 32'h0);
      send_request(shtl_pkg::OP_LOOKUP, 32'h5, 32'h0);
      // unsorted and duplicate hashes
      send_request(shtl_pkg::OP_APPEND, 32'h9, 32'h100);
      send_request(shtl_pkg::OP_APPEND, 32'h2, 32'h200);
      send_request(shtl_pkg::OP_APPEND, 32'h9, 32'h300);
      send_request(shtl_pkg::OP_APPEND, 32'h9, 32'h400);
      send_request(shtl_pkg::OP_APPEND, 32'h1, 32'h500);
      send_request(shtl_pkg::OP_LOOKUP, 32'h2, 32'h0);
      send_request(shtl_pkg::OP_LOOKUP, 32'h9, 32'h0);
      send_request(shtl_pkg::OP_LOOKUP, 32'h1, 32'h0);
      // unused command must not disturb a loaded table
      send_request(shtl_pkg::OP_IGNORE, 32'h9, 32'hDEAD_BEEF);
      send_request(shtl_pkg::OP_LOOKUP, 32'h9, 32'h0);

      // base at its top makes every hit with a nonzero offset wrap around
      write_text_base(32'hFFFF_FFFF);
      run_random_phase(14, 87, 120);
      write_text_base($urandom());
      run_random_phase(87, 14, 120);

      // no idling: fill the table completely behind a long receiver hold-off
      write_text_base(32'h8000_0000);
      send_idle_pct  = 0;
      rsp_stall_pct <= 0;
      rsp_hold_req  <= 1'b1;
      for (i = 0; i < DEPTH; i++) full_keys.push_back($urandom());
      full_keys.sort();
      send_request(shtl_pkg::OP_CLEAR, $urandom(), $urandom());
      foreach (full_keys[k]) send_request(shtl_pkg::OP_APPEND, full_keys[k], $urandom());
      // appends to a full table are refused
      send_request(shtl_pkg::OP_APPEND, 32'h0, 32'hFFFF_FFFF);
      send_request(shtl_pkg::OP_APPEND, 32'hFFFF_FFFF, $urandom());
      send_request(shtl_pkg::OP_APPEND, $urandom(), $urandom());
      // long searches to the first and last index, and a hit on the first probe
      send_request(shtl_pkg::OP_LOOKUP, full_keys[0], $urandom());
      send_request(shtl_pkg::OP_LOOKUP, full_keys[DEPTH-1], $urandom());
      send_request(shtl_pkg::OP_LOOKUP, full_keys[DEPTH/2 - 1], $urandom());
      repeat (60)
         send_request(shtl_pkg::OP_LOOKUP, full_keys[$urandom_range(DEPTH - 1)], $urandom());
      repeat (10) send_request(shtl_pkg::OP_LOOKUP, $urandom(), $urandom());
      run_random_phase(0, 0, 100);

      // drain
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

[filelist.f]
rtl/shtl_pkg.sv
rtl/shtl_front.sv
rtl/shtl_back.sv
rtl/sorted_hash_table_lookup_unit.sv
rtl/shtl_checker.sv
verif/testbench.sv
